// ===== design/assert_macros.svh =====
// Assertion helpers used by mlcc_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mlcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlcc_pkg
// Shared types and constants of the mesh line C1 continuity checker.
// ----------------------------------------------------------------------------
package mlcc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COS_W      = 16;
  localparam int RATIO_W    = 32;
  localparam int QDEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_EPS   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RATIO_TOL_RST = 16'd3277;   // 0.05
  localparam logic [CFG_DATA_W-1:0] COS_THR_RST   = 16'd64881;  // 0.99
  localparam logic [CFG_DATA_W-1:0] LEN_EPS_RST   = 16'd1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_LOAD,
    F_MUL,
    F_ACC,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ1,
    B_SQ2,
    B_EVAL,
    B_DIV,
    B_RCHK,
    B_MUL1,
    B_MUL2,
    B_COS,
    B_END
  } back_state_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] ratio_tol;
    logic [CFG_DATA_W-1:0] cos_thr;
    logic [CFG_DATA_W-1:0] len_eps;
  } cfg_t;

endpackage

// ===== design/mlcc_if.sv =====
// ----------------------------------------------------------------------------
// mlcc interfaces
// Row input, result output and register write channels.
// ----------------------------------------------------------------------------
interface mlcc_row_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y, prev_z;
  logic signed [COORD_WIDTH-1:0] mid_x, mid_y, mid_z;
  logic signed [COORD_WIDTH-1:0] next_x, next_y, next_z;
  logic                          last_row;
  modport source (output valid, prev_x, prev_y, prev_z, mid_x, mid_y, mid_z,
                  next_x, next_y, next_z, last_row, input ready);
  modport sink   (input valid, prev_x, prev_y, prev_z, mid_x, mid_y, mid_z,
                  next_x, next_y, next_z, last_row, output ready);
endinterface

interface mlcc_res_if;
  logic valid;
  logic ready;
  logic continuous;
  modport source (output valid, continuous, input ready);
  modport sink   (input valid, continuous, output ready);
endinterface

interface mlcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mlcc_pkg::CFG_IDX_W-1:0]   index;
  logic [mlcc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mlcc_fifo.sv =====
// ----------------------------------------------------------------------------
// mlcc_fifo
// Short queue between the row front end and the check back end.
// ----------------------------------------------------------------------------
module mlcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

// ===== design/mlcc_front.sv =====
// ----------------------------------------------------------------------------
// mlcc_front
// Takes a row, forms both difference vectors and accumulates squared
// lengths and the signed dot product with a bit-serial multiplier.
// ----------------------------------------------------------------------------
module mlcc_front #(
  parameter int CW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   row_valid_i,
  output logic                   row_ready_o,
  input  logic [8:0][CW-1:0]     coord_i,
  input  logic                   last_i,
  output logic                   push_o,
  input  logic                   full_i,
  output logic [2*CW+3:0]        s1_o,
  output logic [2*CW+3:0]        s2_o,
  output logic [2*CW+3:0]        pos_o,
  output logic [2*CW+3:0]        neg_o,
  output logic                   last_o
);
  localparam int DW  = CW + 1;
  localparam int SW  = 2*DW + 2;
  localparam int FCW = $clog2(DW);

  mlcc_pkg::front_state_e state_q, state_d;

  logic [2:0][DW-1:0] ma_q, mb_q;
  logic [2:0]         sa_q, sb_q;
  logic [1:0]         k_q, t_q;
  logic [2*DW-1:0]    mcand_q, prod_q;
  logic [DW-1:0]      mplier_q;
  logic [FCW-1:0]     cnt_q;
  logic [SW-1:0]      s1_q, s2_q, pos_q, neg_q;
  logic               last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlcc_pkg::F_IDLE: if (row_valid_i) state_d = mlcc_pkg::F_LOAD;
      mlcc_pkg::F_LOAD: state_d = mlcc_pkg::F_MUL;
      mlcc_pkg::F_MUL:  if (cnt_q == '0) state_d = mlcc_pkg::F_ACC;
      mlcc_pkg::F_ACC:  state_d = (k_q == 2'd2 && t_q == 2'd2) ? mlcc_pkg::F_PUSH
                                                                : mlcc_pkg::F_LOAD;
      mlcc_pkg::F_PUSH: if (!full_i) state_d = mlcc_pkg::F_IDLE;
      default:          state_d = mlcc_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    row_ready_o = (state_q == mlcc_pkg::F_IDLE);
    push_o      = (state_q == mlcc_pkg::F_PUSH) && !full_i;
  end

  assign s1_o   = s1_q;
  assign s2_o   = s2_q;
  assign pos_o  = pos_q;
  assign neg_o  = neg_q;
  assign last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlcc_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [DW-1:0] da, db;
    logic [DW-1:0]        opa, opb;
    case (state_q)
      mlcc_pkg::F_IDLE: begin
        if (row_valid_i) begin
          for (int k = 0; k < 3; k++) begin
            da = DW'($signed(coord_i[k]))   - DW'($signed(coord_i[3+k]));
            db = DW'($signed(coord_i[3+k])) - DW'($signed(coord_i[6+k]));
            sa_q[k] <= da[DW-1];
            sb_q[k] <= db[DW-1];
            ma_q[k] <= da[DW-1] ? DW'(-da) : DW'(da);
            mb_q[k] <= db[DW-1] ? DW'(-db) : DW'(db);
          end
          k_q    <= '0;
          t_q    <= '0;
          s1_q   <= '0;
          s2_q   <= '0;
          pos_q  <= '0;
          neg_q  <= '0;
          last_q <= last_i;
        end
      end
      mlcc_pkg::F_LOAD: begin
        // t: 0 -> a*a, 1 -> b*b, 2 -> a*b
        opa      = (t_q == 2'd1) ? mb_q[k_q] : ma_q[k_q];
        opb      = (t_q == 2'd0) ? ma_q[k_q] : mb_q[k_q];
        mcand_q  <= (2*DW)'(opa);
        mplier_q <= opb;
        prod_q   <= '0;
        cnt_q    <= FCW'(DW-1);
      end
      mlcc_pkg::F_MUL: begin
        if (mplier_q[0]) prod_q <= prod_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - 1'b1;
      end
      mlcc_pkg::F_ACC: begin
        case (t_q)
          2'd0: s1_q <= s1_q + SW'(prod_q);
          2'd1: s2_q <= s2_q + SW'(prod_q);
          default: begin
            if (sa_q[k_q] == sb_q[k_q]) pos_q <= pos_q + SW'(prod_q);
            else                        neg_q <= neg_q + SW'(prod_q);
          end
        endcase
        if (t_q == 2'd2) begin
          t_q <= '0;
          k_q <= k_q + 1'b1;
        end else begin
          t_q <= t_q + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== design/mlcc_back.sv =====
// ----------------------------------------------------------------------------
// mlcc_back
// Square roots, ratio division and cosine test of one row, the per-line
// state and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlcc_back #(
  parameter int CW   = 32,
  parameter int FRAC = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlcc_pkg::cfg_t       cfg_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  input  logic [2*CW+3:0]      s1_i,
  input  logic [2*CW+3:0]      s2_i,
  input  logic [2*CW+3:0]      pos_i,
  input  logic [2*CW+3:0]      neg_i,
  input  logic                 last_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic                 res_cont_o
);
  localparam int RW   = CW + 2;                 // root width
  localparam int SW   = 2*RW;
  localparam int QW   = RW + FRAC;
  localparam int QX   = (QW > mlcc_pkg::RATIO_W) ? QW : mlcc_pkg::RATIO_W + 1;
  localparam int PW   = SW + mlcc_pkg::COS_W;
  localparam int CNTW = $clog2(QW);
  localparam int RTW  = mlcc_pkg::RATIO_W;

  mlcc_pkg::back_state_e state_q, state_d;

  logic [SW-1:0]   s2_q, pos_q, neg_q, rad_q;
  logic            last_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q, l1_q, l2_q, mplier_q;
  logic [QW-1:0]   num_q;
  logic [PW-1:0]   acc_q, mcand_q;
  logic [CNTW-1:0] cnt_q;
  logic [RTW-1:0]  t_q, ref_q;
  logic            unset_q, failed_q;
  logic            out_valid_q, out_cont_q;

  logic            pop, out_load, cnt_done;
  logic            l1z, l2z, degen, set_ref, t_inf, match;
  logic [RTW-1:0]  t_val, diff;
  logic [RW+2:0]   sq_rem, sq_trial;
  logic            sq_ge;
  logic [RW:0]     dv_rem;
  logic            dv_ge;
  logic [QX-1:0]   qx;
  logic [SW-1:0]   dot;
  logic            cos_fail;

  assign cnt_done = (cnt_q == '0);
  assign l1z      = (l1_q == '0);
  assign l2z      = (l2_q == '0);
  assign degen    = (l1_q < RW'(cfg_i.len_eps)) && (l2_q < RW'(cfg_i.len_eps));
  assign set_ref  = unset_q && !l1z && !l2z;

  // one root digit per cycle
  assign sq_rem   = {rem_q[RW:0], rad_q[SW-1 -: 2]};
  assign sq_trial = (RW+3)'({root_q, 2'b01});
  assign sq_ge    = (sq_rem >= sq_trial);

  // one quotient bit per cycle, quotient shifts into num_q
  assign dv_rem = {rem_q[RW-1:0], num_q[QW-1]};
  assign dv_ge  = (dv_rem >= (RW+1)'(l2_q));
  // full quotient as it stands after the current step
  assign qx     = QX'({num_q[QW-2:0], dv_ge});

  // row ratio against the reference; a zero second length is infinite unless the first is zero with a reference set
  always_comb begin
    t_val = t_q;
    t_inf = 1'b0;
    if (l2z) begin
      t_inf = l1z ? unset_q : 1'b1;
      t_val = ref_q;
    end
    diff  = (t_val > ref_q) ? t_val - ref_q : ref_q - t_val;
    match = (t_inf || unset_q) ? (t_inf && unset_q)
                               : (diff < RTW'(cfg_i.ratio_tol));
  end

  assign dot      = pos_q - neg_q;
  assign cos_fail = (pos_q < neg_q) || ({dot, 16'b0} < acc_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mlcc_pkg::B_IDLE: if (!empty_i) state_d = failed_q ? mlcc_pkg::B_END
                                                         : mlcc_pkg::B_SQ1;
      mlcc_pkg::B_SQ1:  if (cnt_done) state_d = mlcc_pkg::B_SQ2;
      mlcc_pkg::B_SQ2:  if (cnt_done) state_d = mlcc_pkg::B_EVAL;
      mlcc_pkg::B_EVAL: begin
        if (degen)     state_d = mlcc_pkg::B_END;
        else if (l2z)  state_d = mlcc_pkg::B_RCHK;
        else           state_d = mlcc_pkg::B_DIV;
      end
      mlcc_pkg::B_DIV:  if (cnt_done) state_d = mlcc_pkg::B_RCHK;
      mlcc_pkg::B_RCHK: begin
        if (!set_ref && !match) state_d = mlcc_pkg::B_END;
        else if (!l1z && !l2z)  state_d = mlcc_pkg::B_MUL1;
        else                    state_d = mlcc_pkg::B_END;
      end
      mlcc_pkg::B_MUL1: if (cnt_done) state_d = mlcc_pkg::B_MUL2;
      mlcc_pkg::B_MUL2: if (cnt_done) state_d = mlcc_pkg::B_COS;
      mlcc_pkg::B_COS:  state_d = mlcc_pkg::B_END;
      mlcc_pkg::B_END:  if (!last_q || !out_valid_q || res_ready_i) state_d = mlcc_pkg::B_IDLE;
      default:          state_d = mlcc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state_q == mlcc_pkg::B_IDLE) && !empty_i;
    out_load = (state_q == mlcc_pkg::B_END) && last_q && (!out_valid_q || res_ready_i);
  end

  assign pop_o       = pop;
  assign res_valid_o = out_valid_q;
  assign res_cont_o  = out_cont_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlcc_pkg::B_IDLE;
      ref_q       <= '0;
      unset_q     <= 1'b1;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_cont_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mlcc_pkg::B_RCHK) begin
        if (set_ref) begin
          ref_q   <= t_q;
          unset_q <= 1'b0;
        end else if (!match) begin
          failed_q <= 1'b1;
        end
      end
      if (state_q == mlcc_pkg::B_COS && cos_fail) failed_q <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_cont_q  <= !failed_q;
        ref_q       <= '0;
        unset_q     <= 1'b1;
        failed_q    <= 1'b0;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mlcc_pkg::B_IDLE: begin
        if (pop) begin
          rad_q  <= s1_i;
          s2_q   <= s2_i;
          pos_q  <= pos_i;
          neg_q  <= neg_i;
          last_q <= last_i;
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= CNTW'(RW-1);
        end
      end
      mlcc_pkg::B_SQ1, mlcc_pkg::B_SQ2: begin
        if (cnt_done && state_q == mlcc_pkg::B_SQ1) begin
          l1_q   <= {root_q[RW-2:0], sq_ge};
          rad_q  <= s2_q;
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= CNTW'(RW-1);
        end else begin
          if (sq_ge) begin
            rem_q  <= (RW+2)'(sq_rem - sq_trial);
            root_q <= {root_q[RW-2:0], 1'b1};
          end else begin
            rem_q  <= (RW+2)'(sq_rem);
            root_q <= {root_q[RW-2:0], 1'b0};
          end
          rad_q <= rad_q << 2;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_done) l2_q <= {root_q[RW-2:0], sq_ge};
        end
      end
      mlcc_pkg::B_EVAL: begin
        num_q <= QW'(l1_q) << FRAC;
        rem_q <= '0;
        cnt_q <= CNTW'(QW-1);
      end
      mlcc_pkg::B_DIV: begin
        if (dv_ge) begin
          rem_q <= (RW+2)'(dv_rem - (RW+1)'(l2_q));
          num_q <= {num_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= (RW+2)'(dv_rem);
          num_q <= {num_q[QW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        // ratio saturates above 32 bits
        if (cnt_done) t_q <= (|qx[QX-1:RTW]) ? {RTW{1'b1}} : qx[RTW-1:0];
      end
      mlcc_pkg::B_RCHK: begin
        mcand_q  <= PW'(l1_q);
        mplier_q <= l2_q;
        acc_q    <= '0;
        cnt_q    <= CNTW'(RW-1);
      end
      mlcc_pkg::B_MUL1, mlcc_pkg::B_MUL2: begin
        if (cnt_done && state_q == mlcc_pkg::B_MUL1) begin
          mcand_q  <= mplier_q[0] ? acc_q + mcand_q : acc_q;
          mplier_q <= RW'(cfg_i.cos_thr);
          acc_q    <= '0;
          cnt_q    <= CNTW'(mlcc_pkg::COS_W-1);
        end else begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMP(a_unset_ref_zero, clk_i, rst_ni, unset_q, ref_q == '0,
              "reference ratio set while unset")
  `ASSERT_IMP(a_load_on_last, clk_i, rst_ni, out_load, last_q && state_q == mlcc_pkg::B_END,
              "result loaded outside an end row")
  `ASSERT_NXT(a_failed_skips, clk_i, rst_ni, pop && failed_q, state_q == mlcc_pkg::B_END,
              "row after failure was processed")
endmodule

// ===== design/mesh_line_c1_continuity_check_core.sv =====
// ----------------------------------------------------------------------------
// mesh_line_c1_continuity_check_core
// C1 continuity check of a control mesh across one mesh line.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  rows_i     in   valid/ready    prev/mid/next x,y,z, last_row
//  result_o   out  valid/ready    continuous (only on last_row)
//  cfg_i      in   valid/ready    index, data (always ready)
//
//  The front end takes one row at a time and works it through its bit-serial
//  multiplier before it accepts the next; this sets the row rate. The back end
//  (roots, ratio division, cosine products, one bit per cycle) overlaps it
//  through a two-entry queue.
//  Reset is asynchronous; control and configuration registers return to their defaults.
//  A stalled result only holds the back end on a last row.
// ----------------------------------------------------------------------------
module mesh_line_c1_continuity_check_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlcc_cfg_if.sink    cfg_i,
  mlcc_row_if.sink    rows_i,
  mlcc_res_if.source  result_o
);
  localparam int CW = COORD_WIDTH;
  localparam int SW = 2*CW + 4;
  localparam int QE = 4*SW + 1;

  mlcc_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio_tol <= mlcc_pkg::RATIO_TOL_RST;
      cfg_q.cos_thr   <= mlcc_pkg::COS_THR_RST;
      cfg_q.len_eps   <= mlcc_pkg::LEN_EPS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mlcc_pkg::CFG_RATIO_TOL: cfg_q.ratio_tol <= cfg_i.data;
        mlcc_pkg::CFG_COS_THR:   cfg_q.cos_thr   <= cfg_i.data;
        mlcc_pkg::CFG_LEN_EPS:   cfg_q.len_eps   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [8:0][CW-1:0] coords;
  assign coords = {rows_i.next_z, rows_i.next_y, rows_i.next_x,
                   rows_i.mid_z, rows_i.mid_y, rows_i.mid_x,
                   rows_i.prev_z, rows_i.prev_y, rows_i.prev_x};

  logic          push, full, pop, empty, f_last;
  logic [SW-1:0] f_s1, f_s2, f_pos, f_neg;
  logic [QE-1:0] q_rd;

  mlcc_front #(.CW(CW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_valid_i (rows_i.valid),
    .row_ready_o (rows_i.ready),
    .coord_i     (coords),
    .last_i      (rows_i.last_row),
    .push_o      (push),
    .full_i      (full),
    .s1_o        (f_s1),
    .s2_o        (f_s2),
    .pos_o       (f_pos),
    .neg_o       (f_neg),
    .last_o      (f_last)
  );

  mlcc_fifo #(.WIDTH(QE), .DEPTH(mlcc_pkg::QDEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_s1, f_s2, f_pos, f_neg, f_last}),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rd),
    .empty_o (empty)
  );

  mlcc_back #(.CW(CW), .FRAC(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_o       (pop),
    .s1_i        (q_rd[QE-1 -: SW]),
    .s2_i        (q_rd[QE-1-SW -: SW]),
    .pos_i       (q_rd[QE-1-2*SW -: SW]),
    .neg_i       (q_rd[QE-1-3*SW -: SW]),
    .last_i      (q_rd[0]),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .res_cont_o  (result_o.continuous)
  );
endmodule

// ===== sim/mesh_line_c1_continuity_check_core_tb.sv =====
// ----------------------------------------------------------------------------
// mesh_line_c1_continuity_check_core_tb
// Streams mesh line rows through the continuity checker under random flow
// control, predicts each line verdict in wide integer math and compares.
// ----------------------------------------------------------------------------
module mesh_line_c1_continuity_check_core_tb;

  typedef struct packed {
    logic [0:8][31:0] c;  // prev xyz, mid xyz, next xyz
    logic             last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mlcc_cfg_if        cfg();
  mlcc_row_if #(32)  rows();
  mlcc_res_if        res();

  mesh_line_c1_continuity_check_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .rows_i   (rows),
    .result_o (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] tol_q     = mlcc_pkg::RATIO_TOL_RST;
  logic [15:0] cos_thr_q = mlcc_pkg::COS_THR_RST;
  logic [15:0] eps_q     = mlcc_pkg::LEN_EPS_RST;
  logic [31:0] ref_ratio = '0;
  bit          ref_unset = 1'b1;
  bit          line_failed = 1'b0;

  row_t     row_q[$];
  bit       verdict_q[$];
  bit       any_fail = 1'b0;
  bit       row_acc = 1'b0;
  bit       no_gaps = 1'b0;
  int       hold_req = 0;
  int       idle_cycles = 0;

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] len_ratio(logic [127:0] l1, logic [127:0] l2);
    if (((l1 / l2) >> 16) != 0) return 32'hFFFF_FFFF;
    return 32'((l1 << 16) / l2);
  endfunction

  function automatic void check_row(row_t r);
    logic signed [127:0] a, b, s1, s2, dot;
    logic [127:0] l1, l2;
    logic [31:0] t, d;
    bit t_inf, match;
    s1 = 0; s2 = 0; dot = 0;
    for (int k = 0; k < 3; k++) begin
      a = 128'($signed(r.c[k])) - 128'($signed(r.c[3+k]));
      b = 128'($signed(r.c[3+k])) - 128'($signed(r.c[6+k]));
      s1 += a * a;
      s2 += b * b;
      dot += a * b;
    end
    l1 = isqrt(s1);
    l2 = isqrt(s2);
    if (l1 < eps_q && l2 < eps_q) return;
    if (ref_unset && l1 != 0 && l2 != 0) begin
      ref_ratio = len_ratio(l1, l2);
      ref_unset = 1'b0;
    end else begin
      t = '0;
      if (l2 == 0) begin
        t_inf = (l1 == 0) ? ref_unset : 1'b1;
        t = ref_ratio;
      end else begin
        t_inf = 1'b0;
        t = len_ratio(l1, l2);
      end
      if (t_inf || ref_unset) match = t_inf && ref_unset;
      else begin
        d = (t > ref_ratio) ? t - ref_ratio : ref_ratio - t;
        match = d < tol_q;
      end
      if (!match) begin
        line_failed = 1'b1;
        return;
      end
    end
    if (l1 != 0 && l2 != 0) begin
      // negative dot always fails
      if (dot < 0 || (dot << 16) < $signed(128'(cos_thr_q) * l1 * l2))
        line_failed = 1'b1;
    end
  endfunction

  // monitor: predict on accepted rows, check accepted verdicts
  always @(posedge clk_i) begin
    bit exp_v;
    row_acc = rows.valid && rows.ready;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mlcc_pkg::CFG_RATIO_TOL: tol_q = cfg.data;
          mlcc_pkg::CFG_COS_THR:   cos_thr_q = cfg.data;
          mlcc_pkg::CFG_LEN_EPS:   eps_q = cfg.data;
          default: ;
        endcase
      end
      if (row_acc) begin
        if (!line_failed) check_row({rows.prev_x, rows.prev_y, rows.prev_z,
                                      rows.mid_x, rows.mid_y, rows.mid_z,
                                      rows.next_x, rows.next_y, rows.next_z,
                                      rows.last_row});
        if (rows.last_row) begin
          verdict_q.push_back(!line_failed);
          ref_ratio = '0;
          ref_unset = 1'b1;
          line_failed = 1'b0;
        end
      end
      if (res.valid && res.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result continuous=%0b", res.continuous);
          any_fail = 1'b1;
        end else begin
          exp_v = verdict_q.pop_front();
          if (res.continuous !== exp_v) begin
            $error("continuous: expected %0b, got %0b", exp_v, res.continuous);
            any_fail = 1'b1;
          end
        end
      end
      if (row_acc || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 40000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // row driver
  int   row_gap = 0;
  row_t cur;
  initial begin
    rows.valid = 1'b0;
    {rows.prev_x, rows.prev_y, rows.prev_z, rows.mid_x, rows.mid_y, rows.mid_z,
     rows.next_x, rows.next_y, rows.next_z, rows.last_row} = '0;
  end
  always @(negedge clk_i) begin
    if (rst_ni && (!rows.valid || row_acc)) begin
      if (row_gap > 0) begin
        row_gap--;
        rows.valid <= 1'b0;
      end else if (row_q.size() != 0) begin
        cur = row_q.pop_front();
        {rows.prev_x, rows.prev_y, rows.prev_z, rows.mid_x, rows.mid_y, rows.mid_z,
         rows.next_x, rows.next_y, rows.next_z, rows.last_row} <= cur;
        rows.valid <= 1'b1;
        row_gap = pick_gap();
      end else
        rows.valid <= 1'b0;
    end
  end

  // result sink with random stalls and a long hold-off on each request
  int hold_cnt = 0, hold_seen = 0, res_gap = 0;
  initial res.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 8000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      res.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      res_gap = pick_gap();
    end
  end

  task automatic cfg_write(logic [mlcc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (row_q.size() != 0 || rows.valid || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  // one row of three points on a line through mid, scaled k1 : k2
  function automatic row_t line_row(int k1, int k2, int span, bit last);
    row_t r;
    int m, dd;
    for (int k = 0; k < 3; k++) begin
      m  = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      dd = $signed($urandom_range(0, 2 * span)) - span;
      r.c[k]   = 32'(m + k1 * dd);
      r.c[3+k] = 32'(m);
      r.c[6+k] = 32'(m - k2 * dd);
    end
    r.last = last;
    return r;
  endfunction

  task automatic add_lines(int n_rows);
    int done, len, k1, k2, span, p;
    row_t r;
    done = 0;
    while (done < n_rows) begin
      len  = $urandom_range(1, 6);
      k1   = $urandom_range(1, 8);
      k2   = $urandom_range(1, 8);
      span = 1 << $urandom_range(2, 14);
      for (int i = 0; i < len; i++) begin
        p = $urandom_range(99);
        if (p < 70) r = line_row(k1, k2, span, i == len - 1);
        else if (p < 78) begin
          // same point three times: degenerate row
          r.c[0] = rnd_coord(); r.c[1] = rnd_coord(); r.c[2] = rnd_coord();
          for (int k = 3; k < 9; k++) r.c[k] = r.c[k-3];
          r.last = (i == len - 1);
        end else if (p < 86) begin
          r = line_row(k1, k2, span, i == len - 1);
          r.c[$urandom_range(8)] ^= 32'(1) << $urandom_range(12);
        end else begin
          for (int k = 0; k < 9; k++) r.c[k] = rnd_coord();
          r.last = $urandom_range(3) == 0;
        end
        row_q.push_back(r);
        done++;
      end
    end
  endtask

  function automatic row_t mk(int px, int mx, int nx, bit last);
    row_t r;
    r.c = '0;
    r.c[0] = px; r.c[3] = mx; r.c[6] = nx;
    r.last = last;
    return r;
  endfunction

  initial begin
    row_t r;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset settings
    row_q.push_back(mk(0, 0, 0, 1));                       // degenerate only
    row_q.push_back(mk(20, 10, 0, 0));                     // sets ratio 1.0
    row_q.push_back(mk(40, 20, 0, 0));                     // matches
    row_q.push_back(mk(30, 10, 0, 1));                     // ratio 2 fails
    row_q.push_back(mk(0, 0, 5, 0));                       // L1 zero, no reference
    row_q.push_back(mk(1, 2, 3, 1));                       // ignored after fail
    row_q.push_back(mk(5, 0, 0, 0));                       // L2 zero, ref unset
    row_q.push_back(mk(7, 0, 0, 0));
    row_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 1)); // saturate
    row_q.push_back(mk(0, 10, 0, 1));                      // negative dot
    row_q.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    row_q.push_back(mk(10, 5, 0, 0));
    row_q.push_back(mk(3, 3, 3, 0));                       // both zero, skipped as degenerate
    row_q.push_back(mk(8, 0, 0, 1));                       // infinite vs finite
    r = mk(-1, -1, -1, 1);
    r.c[1] = 32'hFFFF_FFFF; r.c[4] = 32'h0000_0000; r.c[7] = 32'h0000_0001;
    row_q.push_back(r);
    row_q.push_back(mk(32'h7FFF_FFFF, 0, 32'h8000_0001, 1));
    drain();

    // pause, then long receiver hold-off while rows keep coming
    add_lines(120);
    hold_req++;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          cfg_write(mlcc_pkg::CFG_RATIO_TOL, 16'h0000);
          cfg_write(mlcc_pkg::CFG_COS_THR, 16'h0000);
          cfg_write(mlcc_pkg::CFG_LEN_EPS, 16'h0000);
        end
        1: begin
          cfg_write(mlcc_pkg::CFG_RATIO_TOL, 16'hFFFF);
          cfg_write(mlcc_pkg::CFG_COS_THR, 16'hFFFF);
          cfg_write(mlcc_pkg::CFG_LEN_EPS, 16'hFFFF);
        end
        2: begin
          cfg_write(mlcc_pkg::CFG_RATIO_TOL, mlcc_pkg::RATIO_TOL_RST);
          cfg_write(mlcc_pkg::CFG_COS_THR, mlcc_pkg::COS_THR_RST);
          cfg_write(mlcc_pkg::CFG_LEN_EPS, mlcc_pkg::LEN_EPS_RST);
        end
        default: begin
          cfg_write(mlcc_pkg::CFG_RATIO_TOL, 16'($urandom_range(0, 20000)));
          cfg_write(mlcc_pkg::CFG_COS_THR, 16'($urandom_range(50000, 65535)));
          cfg_write(mlcc_pkg::CFG_LEN_EPS, 16'($urandom_range(0, 64)));
        end
      endcase
      no_gaps = (ph == 2);
      add_lines(ph == 2 ? 500 : 300);
      if (ph == 3) hold_req++;
      drain();
    end

    if (!any_fail)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mlcc_pkg.sv
design/mlcc_if.sv
design/mlcc_fifo.sv
design/mlcc_front.sv
design/mlcc_back.sv
design/mesh_line_c1_continuity_check_core.sv
sim/mesh_line_c1_continuity_check_core_tb.sv
